// ===== rtl/core/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// adsr_pkg
// shared types, constants and fixed-point helpers of the adsr envelope step unit
// ----------------------------------------------------------------------------
package adsr_pkg;

    // build constants, signed q8.24
    localparam logic signed [31:0] HOLD_COEF      = 32'sd0;
    localparam logic signed [31:0] PEAK_THRESHOLD = 32'sd0;
    localparam logic signed [31:0] PEAK_LEVEL     = 32'sd146800640;
    localparam logic signed [31:0] SUSTAIN_BASE   = 32'sd0;
    localparam logic signed [31:0] ATTACK_TARGET  = 32'sd146800640;
    localparam logic               TWO_STEP       = 1'b0;

    localparam logic signed [32:0] Q_TWO          = 33'sd33554432;
    localparam logic signed [31:0] SCALE_RESET    = 32'sd16777216;

    localparam int APB_AW = 5;

    // register indexes
    typedef enum logic [2:0] {
        REG_ATTACK  = 3'd0,
        REG_DECAY   = 3'd1,
        REG_RELEASE = 3'd2,
        REG_SUSTAIN = 3'd3,
        REG_SLEW    = 3'd4,
        REG_SMOOTH  = 3'd5,
        REG_THRESH  = 3'd6,
        REG_SCALE   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [30:0]        attack_rate;
        logic [30:0]        decay_rate;
        logic [30:0]        release_rate;
        logic [24:0]        sustain_level;
        logic [30:0]        slew_step;
        logic [24:0]        rate_smoothing;
        logic signed [31:0] release_threshold;
        logic signed [31:0] output_scale;
    } t_cfg;

    // operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        MS_SUS  = 3'd0,
        MS_K2   = 3'd1,
        MS_RATE = 3'd2,
        MS_C2   = 3'd3,
        MS_ENV  = 3'd4,
        MS_OUT  = 3'd5
    } t_mul_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_TGT,
        ST_K2,
        ST_K2W,
        ST_RATE,
        ST_RUPD,
        ST_C2,
        ST_C2W,
        ST_ENV,
        ST_ENVW,
        ST_OUT,
        ST_OUTW
    } t_state;

    typedef struct packed {
        t_mul_sel mul_sel;
        logic     ld_in;
        logic     ld_prep;
        logic     ld_tgt;
        logic     ld_keff;
        logic     ld_rate;
        logic     ld_c2;
        logic     ld_env;
        logic     ld_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_stat;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
        logic signed [31:0] res;
        if (x > 48'sh0000_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (x < -48'sh0000_8000_0000) begin
            res = 32'sh8000_0000;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

    // round half up, drop 24 fraction bits, saturate
    function automatic logic signed [31:0] qround(input logic signed [65:0] p);
        logic signed [66:0] x;
        logic signed [66:0] sh;
        x  = 67'(p) + 67'sd8388608;
        sh = x >>> 24;
        return sat32(sh[47:0]);
    endfunction

endpackage

// ===== rtl/core/adsr_ifs.sv =====
// ----------------------------------------------------------------------------
// adsr stream interfaces
// valid/ready channels for gate items and envelope result items
// ----------------------------------------------------------------------------
interface adsr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] gate_level;

    modport source (output valid, output gate_level, input ready);
    modport sink   (input valid, input gate_level, output ready);
endinterface

interface adsr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] envelope_out;
    logic               at_rest;

    modport source (output valid, output envelope_out, output at_rest, input ready);
    modport sink   (input valid, input envelope_out, input at_rest, output ready);
endinterface

// ===== rtl/core/adsr_regs.sv =====
// ----------------------------------------------------------------------------
// adsr_regs
// apb configuration register file
// ----------------------------------------------------------------------------
module adsr_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [adsr_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output adsr_pkg::t_cfg               o_cfg
);
    import adsr_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg              <= '0;
            r_cfg.output_scale <= SCALE_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ATTACK:  r_cfg.attack_rate       <= pwdata[30:0];
                REG_DECAY:   r_cfg.decay_rate        <= pwdata[30:0];
                REG_RELEASE: r_cfg.release_rate      <= pwdata[30:0];
                REG_SUSTAIN: r_cfg.sustain_level     <= pwdata[24:0];
                REG_SLEW:    r_cfg.slew_step         <= pwdata[30:0];
                REG_SMOOTH:  r_cfg.rate_smoothing    <= pwdata[24:0];
                REG_THRESH:  r_cfg.release_threshold <= pwdata;
                REG_SCALE:   r_cfg.output_scale      <= pwdata;
                default:     r_cfg                   <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ATTACK:  prdata = {1'b0, r_cfg.attack_rate};
            REG_DECAY:   prdata = {1'b0, r_cfg.decay_rate};
            REG_RELEASE: prdata = {1'b0, r_cfg.release_rate};
            REG_SUSTAIN: prdata = {7'b0, r_cfg.sustain_level};
            REG_SLEW:    prdata = {1'b0, r_cfg.slew_step};
            REG_SMOOTH:  prdata = {7'b0, r_cfg.rate_smoothing};
            REG_THRESH:  prdata = r_cfg.release_threshold;
            REG_SCALE:   prdata = r_cfg.output_scale;
            default:     prdata = '0;
        endcase
    end
endmodule

// ===== rtl/core/adsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// adsr_ctrl
// sequencer stepping the datapath through one item
// ----------------------------------------------------------------------------
module adsr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  adsr_pkg::t_dp_stat  i_stat,
    output adsr_pkg::t_dp_cmd   o_cmd
);
    import adsr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_PREP;
            ST_PREP: n_state = ST_TGT;
            ST_TGT:  n_state = TWO_STEP ? ST_K2 : ST_RATE;
            ST_K2:   n_state = ST_K2W;
            ST_K2W:  n_state = ST_RATE;
            ST_RATE: n_state = ST_RUPD;
            ST_RUPD: n_state = TWO_STEP ? ST_C2 : ST_ENV;
            ST_C2:   n_state = ST_C2W;
            ST_C2W:  n_state = ST_ENV;
            ST_ENV:  n_state = ST_ENVW;
            ST_ENVW: n_state = ST_OUT;
            ST_OUT:  n_state = ST_OUTW;
            ST_OUTW: if (i_stat.out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.mul_sel = MS_SUS;
        o_cmd.ld_in   = 1'b0;
        o_cmd.ld_prep = 1'b0;
        o_cmd.ld_tgt  = 1'b0;
        o_cmd.ld_keff = 1'b0;
        o_cmd.ld_rate = 1'b0;
        o_cmd.ld_c2   = 1'b0;
        o_cmd.ld_env  = 1'b0;
        o_cmd.ld_out  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.ld_in = i_in_valid;
            end
            ST_PREP: begin
                o_cmd.ld_prep = 1'b1;
                o_cmd.mul_sel = MS_SUS;
            end
            ST_TGT:  o_cmd.ld_tgt = 1'b1;
            ST_K2:   o_cmd.mul_sel = MS_K2;
            ST_K2W:  o_cmd.ld_keff = 1'b1;
            ST_RATE: o_cmd.mul_sel = MS_RATE;
            ST_RUPD: o_cmd.ld_rate = 1'b1;
            ST_C2:   o_cmd.mul_sel = MS_C2;
            ST_C2W:  o_cmd.ld_c2 = 1'b1;
            ST_ENV:  o_cmd.mul_sel = MS_ENV;
            ST_ENVW: o_cmd.ld_env = 1'b1;
            ST_OUT:  o_cmd.mul_sel = MS_OUT;
            ST_OUTW: begin
                o_cmd.mul_sel = MS_OUT;
                o_cmd.ld_out  = i_stat.out_free;
            end
            default: o_in_ready = 1'b0;
        endcase
    end
endmodule

// ===== rtl/core/adsr_dp.sv =====
// ----------------------------------------------------------------------------
// adsr_dp
// envelope state, shared multiplier and output register
// ----------------------------------------------------------------------------
module adsr_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  adsr_pkg::t_cfg      i_cfg,
    input  adsr_pkg::t_dp_cmd   i_cmd,
    output adsr_pkg::t_dp_stat  o_stat,
    input  logic signed [31:0]  i_gate_level,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_envelope_out,
    output logic                o_at_rest
);
    import adsr_pkg::*;

    // envelope state
    logic signed [31:0] r_env, r_hold, r_tgt, r_rate;
    logic               r_phase;
    // per-item working registers
    logic               r_gh, r_atk;
    logic [22:0]        r_rsel;
    logic signed [31:0] r_err, r_keff, r_c;
    logic signed [65:0] r_prod;
    // result register
    logic               r_ovalid;
    logic signed [31:0] r_oenv;
    logic               r_orest;

    logic signed [32:0] w_gsum;
    logic signed [31:0] w_nh, w_q, w_s0, w_s1, w_slew, w_nt, w_err, w_nr, w_ny;
    logic signed [33:0] w_pk;
    logic               w_np, w_atk;
    logic [22:0]        w_rsel;
    logic [31:0]        w_step;
    logic signed [32:0] w_ma, w_mb, w_k, w_keff;

    assign w_gsum = 33'(i_gate_level) + 33'(i_cfg.release_threshold);

    // hold, phase and rate select
    always_comb begin
        w_nh = r_gh ? sat32(48'(r_phase ? HOLD_COEF : 32'sd0) + 48'(r_env)) : 32'sd0;
        w_pk = 34'(w_nh) + 34'(PEAK_THRESHOLD);
        w_np = !w_pk[33];
        if (w_nh < r_hold) begin
            w_np = r_gh;
        end
        w_atk = r_gh & !w_np;
        if (w_np) begin
            w_rsel = i_cfg.decay_rate[30:8];
        end else if (w_atk) begin
            w_rsel = i_cfg.attack_rate[30:8];
        end else begin
            w_rsel = '0;
        end
    end

    assign w_q = qround(r_prod);

    // sustain target slew and stage error
    always_comb begin
        w_step = TWO_STEP ? {i_cfg.slew_step, 1'b0} : {1'b0, i_cfg.slew_step};
        w_s0   = r_gh ? w_q : SUSTAIN_BASE;
        w_slew = sat32(48'(r_tgt) + 48'($signed({16'b0, w_step})));
        w_s1   = (w_s0 > r_tgt) ? w_slew : w_s0;
        w_nt   = (PEAK_LEVEL < w_s1) ? PEAK_LEVEL : w_s1;
        w_err  = sat32((r_atk ? 48'(ATTACK_TARGET) : 48'sd0)
                     + (r_phase ? 48'(w_nt) : 48'sd0) - 48'(r_env));
    end

    assign w_nr = sat32(48'(r_rate) + 48'(w_q));
    assign w_ny = sat32(48'(r_env) + 48'(w_q));

    // shared multiplier operands
    assign w_k    = $signed({8'b0, i_cfg.rate_smoothing});
    assign w_keff = TWO_STEP ? 33'(r_keff) : w_k;

    always_comb begin
        case (i_cmd.mul_sel)
            MS_SUS: begin
                w_ma = $signed({8'b0, i_cfg.sustain_level});
                w_mb = 33'(PEAK_LEVEL);
            end
            MS_K2: begin
                w_ma = w_k;
                w_mb = Q_TWO - w_k;
            end
            MS_RATE: begin
                w_ma = w_keff;
                w_mb = $signed({10'b0, r_rsel}) - 33'(r_rate);
            end
            MS_C2: begin
                w_ma = 33'(r_c);
                w_mb = Q_TWO - 33'(r_c);
            end
            MS_ENV: begin
                w_ma = 33'(r_c);
                w_mb = 33'(r_err);
            end
            MS_OUT: begin
                w_ma = 33'(r_env);
                w_mb = 33'(i_cfg.output_scale);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env    <= '0;
            r_hold   <= '0;
            r_phase  <= 1'b0;
            r_tgt    <= '0;
            r_rate   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.ld_prep) begin
                r_hold  <= w_nh;
                r_phase <= w_np;
            end
            if (i_cmd.ld_tgt) begin
                r_tgt <= w_nt;
            end
            if (i_cmd.ld_rate) begin
                r_rate <= w_nr;
            end
            if (i_cmd.ld_env) begin
                r_env <= w_ny;
            end
            if (i_cmd.ld_out) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // working payload
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        if (i_cmd.ld_in) begin
            r_gh <= !w_gsum[32];
        end
        if (i_cmd.ld_prep) begin
            r_atk  <= w_atk;
            r_rsel <= w_rsel;
        end
        if (i_cmd.ld_tgt) begin
            r_err <= w_err;
        end
        if (i_cmd.ld_keff) begin
            r_keff <= w_q;
        end
        if (i_cmd.ld_rate) begin
            r_c <= r_gh ? w_nr : $signed({9'b0, i_cfg.release_rate[30:8]});
        end else if (i_cmd.ld_c2) begin
            r_c <= w_q;
        end
        if (i_cmd.ld_out) begin
            r_oenv  <= w_q;
            r_orest <= (r_env == 32'sd0) && (r_hold == 32'sd0)
                    && (r_tgt == 32'sd0) && (r_rate == 32'sd0);
        end
    end

    assign o_stat.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid     = r_ovalid;
    assign o_envelope_out  = r_oenv;
    assign o_at_rest       = r_orest;
endmodule

// ===== rtl/core/adsr_envelope_step_unit.sv =====
// ----------------------------------------------------------------------------
// adsr_envelope_step_unit
// accepts a new gate item only once the previous result is in the result register; the
// single shared multiplier is walked by the sequencer through sustain, rate, envelope and
//   output products (and the k2 and c2 products in the two-step build)
// reset: synchronous active low, clears envelope state and output valid, output_scale to 1.0
// ----------------------------------------------------------------------------
module adsr_envelope_step_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    adsr_in_if.sink                     i_in,
    adsr_out_if.source                  o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [adsr_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import adsr_pkg::*;

    t_cfg     w_cfg;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // configuration registers; write them only while no item is in flight (not enforced here)
    adsr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sequencer: takes an item only when idle, holds the last step
    // until the result register has room
    adsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath: state registers, one 33x33 multiplier with a registered
    // product, rounding/saturation and the result register that lets the
    // next item enter while a result still waits
    adsr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_gate_level   (i_in.gate_level),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_envelope_out (o_out.envelope_out),
        .o_at_rest      (o_out.at_rest)
    );
endmodule
